/* hw/rtl/qaltok_pkg.sv */
// package for the quoted argument line tokenizer
// character codes, parse modes, verdict codes, widths, default sizes and a white-space test; no dependencies
package qaltok_pkg;

  // default sizes
  localparam int MAX_ARG_LEN_DEF = 256;
  localparam int MAX_ARGS_DEF    = 16;

  // widths fixed by the interface
  localparam int CH_W     = 8;
  localparam int CFG_W    = 5;
  localparam int IDX_W    = 4;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;

  localparam logic [CFG_W-1:0] CFG_MAX_TOKENS_RST = 5'd16;

  // character codes
  localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CH_W-1:0] CH_SEMI  = 8'h3B;
  localparam logic [CH_W-1:0] CH_HASH  = 8'h23;
  localparam logic [CH_W-1:0] CH_BSL   = 8'h5C;
  localparam logic [CH_W-1:0] CH_DQ    = 8'h22;
  localparam logic [CH_W-1:0] CH_SQ    = 8'h27;

  // parse modes
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_DQ   = 2'd1;
  localparam logic [1:0] MODE_UNQ  = 2'd2;
  localparam logic [1:0] MODE_SQ   = 2'd3;

  // line verdicts
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_ESC  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_LONG = 3'd2;
  localparam logic [STATUS_W-1:0] ST_OPEN_DQ  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OPEN_SQ  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_RESIDUAL = 3'd5;

  // white space, the zero byte included
  function automatic logic is_blank(input logic [CH_W-1:0] c);
    return (c == CH_NUL) || (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

/* hw/rtl/quoted_argument_line_tokenizer.sv */
// top level of the quoted argument line tokenizer: input register, per-byte
// parser and result register; depends on qaltok_pkg
//
// Takes one line byte per request and gives exactly one result per request.
// A byte is accepted in every cycle in which in_ready is high; in_ready only
// drops when both the input register and the result register hold requests
// that the consumer has not taken. A byte passes the input, then the result
// register. The whole parse step (quotes, escapes, comments, limits, the
// verdict on the terminating zero) is one short combinational pass from the
// input register to the result register, and the line state is updated at
// the same edge, so the sustained rate is one byte per cycle while out_ready
// stays high. Arguments are split on white space; a backslash escapes a
// backslash, double quote or white space outside single quotes; ';' or '#'
// between arguments ends the line. Once a line halts (comment, argument
// limit, error) bytes are ignored up to the zero, which reports status and
// argument count and starts the next line. cfg_wdata sets the argument limit,
// saturated to 1..MAX_ARGS, and may only be written while the block is idle.
module quoted_argument_line_tokenizer
  import qaltok_pkg::*;
#(
  parameter int MAX_ARG_LEN = MAX_ARG_LEN_DEF,
  parameter int MAX_ARGS    = MAX_ARGS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  // configuration
  input  logic                cfg_we,
  input  logic [CFG_W-1:0]    cfg_wdata,
  // byte stream in
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [CH_W-1:0]     in_ch,
  // results out
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_char_valid,
  output logic [CH_W-1:0]     out_char_out,
  output logic                out_token_end,
  output logic [IDX_W-1:0]    out_token_index,
  output logic                out_line_done,
  output logic [STATUS_W-1:0] out_status,
  output logic [COUNT_W-1:0]  out_token_count
);

  localparam int LEN_W = $clog2(MAX_ARG_LEN + 1);
  localparam int NUM_W = $clog2(MAX_ARGS + 1);

  // configuration register
  logic [CFG_W-1:0] max_tokens_r;

  // input register
  logic            s1_valid_r;
  logic [CH_W-1:0] s1_ch_r;

  // line state
  logic [1:0]          mode_r,   mode_nxt;
  logic                esc_r,    esc_nxt;
  logic [LEN_W-1:0]    len_r,    len_nxt;
  logic [NUM_W-1:0]    num_r,    num_nxt;
  logic                halted_r, halted_nxt;
  logic [STATUS_W-1:0] lstat_r,  lstat_nxt;

  // result of the current byte
  logic                res_char_valid;
  logic [CH_W-1:0]     res_char;
  logic                res_end;
  logic [NUM_W-1:0]    res_idx;
  logic                res_done;
  logic [STATUS_W-1:0] res_status;
  logic [NUM_W-1:0]    res_count;

  // result register
  logic                out_valid_r;
  logic                out_char_valid_r;
  logic [CH_W-1:0]     out_char_r;
  logic                out_end_r;
  logic [IDX_W-1:0]    out_idx_r;
  logic                out_done_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [COUNT_W-1:0]  out_count_r;

  logic             advance;
  logic [NUM_W-1:0] limit;

  // the input register moves on whenever the result register is free or being emptied
  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || advance;

  // argument limit saturated to 1..MAX_ARGS
  always_comb begin
    if (32'(max_tokens_r) > MAX_ARGS) begin
      limit = NUM_W'(MAX_ARGS);
    end else if (max_tokens_r == '0) begin
      limit = NUM_W'(1);
    end else begin
      limit = NUM_W'(max_tokens_r);
    end
  end

  // per-byte parse step
  always_comb begin
    logic            bs;
    logic            fin;
    logic [CH_W-1:0] o;
    logic            comment;
    logic            c_is_nul;

    mode_nxt       = mode_r;
    esc_nxt        = esc_r;
    len_nxt        = len_r;
    num_nxt        = num_r;
    halted_nxt     = halted_r;
    lstat_nxt      = lstat_r;
    res_char_valid = 1'b0;
    res_char       = '0;
    res_end        = 1'b0;
    res_idx        = '0;
    res_done       = 1'b0;
    res_status     = ST_OK;
    res_count      = '0;
    bs             = esc_r;
    fin            = 1'b0;
    o              = '0;
    comment        = 1'b0;
    c_is_nul       = (s1_ch_r == CH_NUL);

    if (!halted_r) begin
      if (!esc_r && s1_ch_r == CH_BSL && mode_r != MODE_SQ) begin
        esc_nxt = 1'b1;
      end else begin
        case (mode_r)
          MODE_IDLE: begin
            if (!is_blank(s1_ch_r)) begin
              if (s1_ch_r == CH_SEMI || s1_ch_r == CH_HASH) begin
                comment = 1'b1;
              end else if (!bs && s1_ch_r == CH_DQ) begin
                mode_nxt = MODE_DQ;
              end else if (!bs && s1_ch_r == CH_SQ) begin
                mode_nxt = MODE_SQ;
              end else begin
                o        = s1_ch_r;
                mode_nxt = MODE_UNQ;
              end
            end
          end
          MODE_UNQ: begin
            if (!bs && is_blank(s1_ch_r)) fin = 1'b1;
            else o = s1_ch_r;
          end
          MODE_DQ: begin
            if (!bs && s1_ch_r == CH_DQ) fin = 1'b1;
            else o = s1_ch_r;
          end
          MODE_SQ: begin
            if (s1_ch_r == CH_SQ) fin = 1'b1;
            else o = s1_ch_r;
          end
          default: begin
            o = '0;
          end
        endcase

        if (comment) begin
          halted_nxt = 1'b1;
          lstat_nxt  = ST_OK;
        end else begin
          if (fin) begin
            res_end  = 1'b1;
            res_idx  = num_r;
            mode_nxt = MODE_IDLE;
            len_nxt  = '0;
            num_nxt  = num_r + NUM_W'(1);
          end
          esc_nxt = 1'b0;
          if (bs && o != CH_NUL &&
              !(o == CH_BSL || o == CH_DQ || is_blank(o))) begin
            halted_nxt = 1'b1;
            lstat_nxt  = ST_BAD_ESC;
          end else if (o != CH_NUL) begin
            if (32'(len_r) >= MAX_ARG_LEN) begin
              halted_nxt = 1'b1;
              lstat_nxt  = ST_TOO_LONG;
            end else begin
              len_nxt        = len_r + LEN_W'(1);
              res_char_valid = 1'b1;
              res_char       = o;
              res_idx        = num_nxt;
            end
          end
          if (!halted_nxt && num_nxt >= limit) begin
            halted_nxt = 1'b1;
            lstat_nxt  = ST_OK;
          end
        end
      end

      // verdict for a line that ran to its zero byte
      if (c_is_nul && !halted_nxt) begin
        case (mode_nxt)
          MODE_DQ:  lstat_nxt = ST_OPEN_DQ;
          MODE_SQ:  lstat_nxt = ST_OPEN_SQ;
          MODE_UNQ: lstat_nxt = ST_RESIDUAL;
          default:  lstat_nxt = ST_OK;
        endcase
      end
    end

    // zero byte closes the line and starts the next one
    if (c_is_nul) begin
      res_done   = 1'b1;
      res_status = lstat_nxt;
      res_count  = (lstat_nxt == ST_OK) ? num_nxt : '0;
      mode_nxt   = MODE_IDLE;
      esc_nxt    = 1'b0;
      len_nxt    = '0;
      num_nxt    = '0;
      halted_nxt = 1'b0;
      lstat_nxt  = ST_OK;
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_tokens_r <= CFG_MAX_TOKENS_RST;
    end else if (cfg_we) begin
      max_tokens_r <= cfg_wdata;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_ch_r <= in_ch;
    end
  end

  // line state, updated as a byte moves into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      esc_r    <= 1'b0;
      len_r    <= '0;
      num_r    <= '0;
      halted_r <= 1'b0;
      lstat_r  <= ST_OK;
    end else if (s1_valid_r && advance) begin
      mode_r   <= mode_nxt;
      esc_r    <= esc_nxt;
      len_r    <= len_nxt;
      num_r    <= num_nxt;
      halted_r <= halted_nxt;
      lstat_r  <= lstat_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && advance) begin
      out_char_valid_r <= res_char_valid;
      out_char_r       <= res_char;
      out_end_r        <= res_end;
      out_idx_r        <= IDX_W'(res_idx);
      out_done_r       <= res_done;
      out_status_r     <= res_status;
      out_count_r      <= COUNT_W'(res_count);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_char_valid  = out_char_valid_r;
  assign out_char_out    = out_char_r;
  assign out_token_end   = out_end_r;
  assign out_token_index = out_idx_r;
  assign out_line_done   = out_done_r;
  assign out_status      = out_status_r;
  assign out_token_count = out_count_r;

  // the zero byte never carries an argument character
  a_no_char_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_char_valid_r |-> !out_done_r)
    else $error("argument character on line end");

  // a failed line reports no argument count
  a_count_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != ST_OK |-> out_count_r == '0)
    else $error("argument count on failed line");

  // an escape is never pending inside single quotes
  a_no_esc_in_sq: assert property (@(posedge clk) disable iff (!rst_n)
    esc_r |-> mode_r != MODE_SQ)
    else $error("escape pending in single quotes");

  // counters stay within their limits
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(len_r) <= MAX_ARG_LEN)
    else $error("argument length past limit");

  a_num_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(num_r) <= MAX_ARGS)
    else $error("argument count past limit");

endmodule

/* tb/sv/tb_quoted_argument_line_tokenizer.sv */
`timescale 1ns / 1ps
// self-checking testbench for the quoted argument line tokenizer: random and directed lines,
// random stalls on both channels; depends on qaltok_pkg and quoted_argument_line_tokenizer
module tb_quoted_argument_line_tokenizer;
  import qaltok_pkg::*;

  // one result request as seen on the out_ side
  typedef struct packed {
    logic                char_valid;
    logic [CH_W-1:0]     char_out;
    logic                token_end;
    logic [IDX_W-1:0]    token_index;
    logic                line_done;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  token_count;
  } tok_result_t;

  // keeps a shadow of the line parser and the queue of results still owed by the block
  class tokenizer_scoreboard;
    tok_result_t         pending_results[$];
    logic [CFG_W-1:0]    limit_reg;
    logic [1:0]          mode;
    bit                  esc;
    logic [8:0]          arg_len;
    logic [COUNT_W-1:0]  arg_num;
    bit                  halted;
    logic [STATUS_W-1:0] verdict;
    int unsigned         errors;

    function new();
      limit_reg = CFG_MAX_TOKENS_RST;
      errors    = 0;
      start_line();
    endfunction

    static function bit ws_byte(logic [CH_W-1:0] c);
      return c == CH_NUL || c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function void start_line();
      mode    = MODE_IDLE;
      esc     = 1'b0;
      arg_len = '0;
      arg_num = '0;
      halted  = 1'b0;
      verdict = ST_OK;
    endfunction

    // work out the result of one accepted byte and queue it
    function void predict_byte(logic [CH_W-1:0] c);
      tok_result_t      r;
      logic [CFG_W-1:0] lim;
      logic [CH_W-1:0]  o;
      bit               fin;
      bit               bs;
      r   = '0;
      lim = limit_reg;
      if (lim < 1) lim = CFG_W'(1);
      if (lim > MAX_ARGS_DEF) lim = CFG_W'(MAX_ARGS_DEF);
      if (!halted) begin
        if (!esc && c == CH_BSL && mode != MODE_SQ) begin
          esc = 1'b1;
        end else begin
          o   = '0;
          fin = 1'b0;
          bs  = esc;
          case (mode)
            MODE_IDLE: begin
              if (!ws_byte(c)) begin
                if (c == CH_SEMI || c == CH_HASH) begin
                  halted  = 1'b1;
                  verdict = ST_OK;
                end else if (!bs && c == CH_DQ) begin
                  mode = MODE_DQ;
                end else if (!bs && c == CH_SQ) begin
                  mode = MODE_SQ;
                end else begin
                  o    = c;
                  mode = MODE_UNQ;
                end
              end
            end
            MODE_UNQ: begin
              if (!bs && ws_byte(c)) fin = 1'b1;
              else o = c;
            end
            MODE_DQ: begin
              if (!bs && c == CH_DQ) fin = 1'b1;
              else o = c;
            end
            default: begin
              if (c == CH_SQ) fin = 1'b1;
              else o = c;
            end
          endcase
          if (!halted) begin
            if (fin) begin
              r.token_end   = 1'b1;
              r.token_index = arg_num[IDX_W-1:0];
              mode          = MODE_IDLE;
              arg_len       = '0;
              arg_num       = arg_num + COUNT_W'(1);
            end
            esc = 1'b0;
            if (bs && o != 0 && !(o == CH_BSL || o == CH_DQ || ws_byte(o))) begin
              halted  = 1'b1;
              verdict = ST_BAD_ESC;
            end else if (o != 0) begin
              if (arg_len >= MAX_ARG_LEN_DEF) begin
                halted  = 1'b1;
                verdict = ST_TOO_LONG;
              end else begin
                arg_len       = arg_len + 9'd1;
                r.char_valid  = 1'b1;
                r.char_out    = o;
                r.token_index = arg_num[IDX_W-1:0];
              end
            end
            if (!halted && arg_num >= lim) begin
              halted  = 1'b1;
              verdict = ST_OK;
            end
          end
        end
        if (c == CH_NUL && !halted) begin
          if (mode == MODE_DQ) verdict = ST_OPEN_DQ;
          else if (mode == MODE_SQ) verdict = ST_OPEN_SQ;
          else if (mode != MODE_IDLE) verdict = ST_RESIDUAL;
          else verdict = ST_OK;
        end
      end
      if (c == CH_NUL) begin
        r.line_done   = 1'b1;
        r.status      = verdict;
        r.token_count = (verdict == ST_OK) ? arg_num : '0;
        start_line();
      end
      pending_results.push_back(r);
    endfunction

    function void check_field(string name, logic [CH_W-1:0] want, logic [CH_W-1:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= 200)
          $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    function void check_result(tok_result_t got);
      tok_result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 200)
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
        return;
      end
      want = pending_results.pop_front();
      check_field("char_valid", CH_W'(want.char_valid), CH_W'(got.char_valid));
      check_field("char_out", want.char_out, got.char_out);
      check_field("token_end", CH_W'(want.token_end), CH_W'(got.token_end));
      check_field("token_index", CH_W'(want.token_index), CH_W'(got.token_index));
      check_field("line_done", CH_W'(want.line_done), CH_W'(got.line_done));
      check_field("status", CH_W'(want.status), CH_W'(got.status));
      check_field("token_count", CH_W'(want.token_count), CH_W'(got.token_count));
    endfunction
  endclass

  localparam int unsigned CYCLE_LIMIT = 200000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CFG_W-1:0]    cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [CH_W-1:0]     in_ch = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                out_char_valid;
  logic [CH_W-1:0]     out_char_out;
  logic                out_token_end;
  logic [IDX_W-1:0]    out_token_index;
  logic                out_line_done;
  logic [STATUS_W-1:0] out_status;
  logic [COUNT_W-1:0]  out_token_count;

  tokenizer_scoreboard sb = new();

  // stimulus bookkeeping
  logic [CH_W-1:0] line_q[$];
  int unsigned     sent_bytes = 0;
  int unsigned     gen_limit = MAX_ARGS_DEF;
  bit              idle_on = 1'b1;
  int unsigned     stall_left = 0;
  int unsigned     cycles = 0;

  quoted_argument_line_tokenizer u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_ch           (in_ch),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_char_valid  (out_char_valid),
    .out_char_out    (out_char_out),
    .out_token_end   (out_token_end),
    .out_token_index (out_token_index),
    .out_line_done   (out_line_done),
    .out_status      (out_status),
    .out_token_count (out_token_count)
  );

  always #5 clk = ~clk;

  // watchdog: a hung handshake ends the run as a failure
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // consumer side: out_ready drops in random bursts while idling is on
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 5);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // both handshakes are sampled here with pre-edge values; the input is noted first
  // although, with the input and result registers in between, the order does not matter
  always @(posedge clk) begin : monitor_p
    tok_result_t seen;
    if (rst_n) begin
      if (in_valid && in_ready) sb.predict_byte(in_ch);
      if (out_valid && out_ready) begin
        seen.char_valid  = out_char_valid;
        seen.char_out    = out_char_out;
        seen.token_end   = out_token_end;
        seen.token_index = out_token_index;
        seen.line_done   = out_line_done;
        seen.status      = out_status;
        seen.token_count = out_token_count;
        sb.check_result(seen);
      end
    end
  end

  // white space byte: space or one of tab .. carriage return
  function automatic logic [CH_W-1:0] blank_byte();
    int unsigned k;
    k = $urandom_range(0, 5);
    return (k == 0) ? CH_SPACE : CH_TAB + CH_W'(k - 1);
  endfunction

  // byte that may sit in an unquoted argument; a leading one must not open a quote or comment
  function automatic logic [CH_W-1:0] plain_byte(input bit lead);
    logic [CH_W-1:0] b;
    do b = CH_W'($urandom_range(1, 255));
    while (tokenizer_scoreboard::ws_byte(b) || b == CH_BSL ||
           (lead && (b == CH_DQ || b == CH_SQ || b == CH_SEMI || b == CH_HASH)));
    return b;
  endfunction

  // non-zero byte other than the two given
  function automatic logic [CH_W-1:0] byte_except(input logic [CH_W-1:0] a,
                                                   input logic [CH_W-1:0] b);
    logic [CH_W-1:0] v;
    do v = CH_W'($urandom_range(1, 255));
    while (v == a || v == b);
    return v;
  endfunction

  // legal escape target: backslash, double quote or white space
  function automatic logic [CH_W-1:0] escapable_byte();
    case ($urandom_range(0, 3))
      0:       return CH_BSL;
      1:       return CH_DQ;
      2:       return CH_SPACE;
      default: return blank_byte();
    endcase
  endfunction

  task automatic push_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) line_q.push_back(CH_W'(s[i]));
  endtask

  // kind 0 unquoted, 1 double-quoted, 2 single-quoted; len counts content bytes
  task automatic add_token(input int kind, input int len);
    int i;
    if (kind == 1) line_q.push_back(CH_DQ);
    if (kind == 2) line_q.push_back(CH_SQ);
    for (i = 0; i < len; i++) begin
      if (kind != 2 && $urandom_range(0, 7) == 0) begin
        line_q.push_back(CH_BSL);
        line_q.push_back(escapable_byte());
      end else if (kind == 0) begin
        line_q.push_back(plain_byte(i == 0));
      end else if (kind == 1) begin
        line_q.push_back(byte_except(CH_DQ, CH_BSL));
      end else begin
        line_q.push_back(byte_except(CH_SQ, CH_SQ));
      end
    end
    if (kind == 1) line_q.push_back(CH_DQ);
    if (kind == 2) line_q.push_back(CH_SQ);
  endtask

  // builds one random line ending in the zero byte
  task automatic make_line();
    int roll;
    int n;
    int i;
    int kind;
    int seps;
    roll = $urandom_range(0, 99);
    seps = 0;
    if (roll < 8) begin
      // noise: arbitrary bytes
      n = $urandom_range(0, 12);
      for (i = 0; i < n; i++) line_q.push_back(CH_W'($urandom_range(1, 255)));
    end else begin
      repeat ($urandom_range(0, 2)) line_q.push_back(blank_byte());
      // up to one past the limit so the limit halt is reached often
      n = $urandom_range(0, gen_limit + 1);
      for (i = 0; i < n; i++) begin
        kind = $urandom_range(0, 2);
        add_token(kind, (kind == 0 ? 1 : 0) +
                  ($urandom_range(0, 49) == 0 ? $urandom_range(16, 40) : $urandom_range(0, 6)));
        seps = $urandom_range(1, 3);
        repeat (seps) line_q.push_back(blank_byte());
      end
      // sometimes let the zero byte close the last argument
      if (n > 0 && $urandom_range(0, 3) == 0) repeat (seps) void'(line_q.pop_back());
      if (roll < 26) begin
        case ($urandom_range(0, 4))
          0: begin
            // bad escape, optionally inside double quotes
            if ($urandom_range(0, 1) == 1) line_q.push_back(CH_DQ);
            line_q.push_back(CH_BSL);
            line_q.push_back(plain_byte(1'b0) == CH_DQ ? CH_SQ : byte_except(CH_DQ, CH_BSL));
            repeat ($urandom_range(0, 3)) line_q.push_back(CH_W'($urandom_range(1, 255)));
          end
          1: begin
            line_q.push_back(CH_DQ);
            repeat ($urandom_range(0, 3)) line_q.push_back(byte_except(CH_DQ, CH_BSL));
          end
          2: begin
            line_q.push_back(CH_SQ);
            repeat ($urandom_range(0, 3)) line_q.push_back(byte_except(CH_SQ, CH_SQ));
          end
          3: begin
            // escaped zero byte in an unquoted argument
            line_q.push_back(plain_byte(1'b1));
            repeat ($urandom_range(0, 2)) line_q.push_back(plain_byte(1'b0));
            line_q.push_back(CH_BSL);
          end
          default: begin
            // a comment character still ends the line after a backslash
            line_q.push_back(CH_BSL);
            line_q.push_back($urandom_range(0, 1) ? CH_SEMI : CH_HASH);
            repeat ($urandom_range(0, 4)) line_q.push_back(CH_W'($urandom_range(1, 255)));
          end
        endcase
      end else if (roll < 38) begin
        line_q.push_back($urandom_range(0, 1) ? CH_SEMI : CH_HASH);
        repeat ($urandom_range(0, 6)) line_q.push_back(CH_W'($urandom_range(1, 255)));
      end
    end
    line_q.push_back(CH_NUL);
  endtask

  // sends the queued line, one request per byte, with random gaps while idling is on
  task automatic send_line();
    int i;
    for (i = 0; i < line_q.size(); i++) begin
      in_valid <= 1'b1;
      in_ch    <= line_q[i];
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      if (idle_on && $urandom_range(0, 7) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    sent_bytes += line_q.size();
    line_q.delete();
  endtask

  // stop sending and wait until every owed result has been taken; the first edge lets
  // the monitor note a request accepted at the edge just passed
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  // the limit register is only written with nothing in flight
  task automatic write_limit(input logic [CFG_W-1:0] v);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we       <= 1'b0;
    sb.limit_reg  = v;
    gen_limit     = (v < 1) ? 1 : (v > MAX_ARGS_DEF) ? MAX_ARGS_DEF : v;
  endtask

  // phase settings: reset value, both saturating ends, the extremes and a few in between
  logic [CFG_W-1:0] phase_limit[8] = '{5'd16, 5'd0, 5'd1, 5'd31, 5'd2, 5'd17, 5'd9, 5'd0};

  initial begin : stimulus_p
    int p;
    int unsigned goal;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    for (p = 0; p < 8; p++) begin
      // one phase in the middle and the last one run without any idling
      idle_on = (p != 3) && (p != 7);
      write_limit(p == 7 ? CFG_W'($urandom_range(0, 31)) : phase_limit[p]);
      if (p == 0) begin
        // quoted argument with escaped quote, single quote keeping a backslash and
        // the top byte value, then a comment
        push_text("\"a\\\"b\" 'c\\");
        line_q.push_back(8'hFF);
        push_text("' ;z");
        line_q.push_back(CH_NUL);
        send_line();
        // bad escape
        push_text("\\q");
        line_q.push_back(CH_NUL);
        send_line();
        // empty single-quoted argument, then an unclosed double quote
        push_text("'' \"x");
        line_q.push_back(CH_NUL);
        send_line();
        // escaped zero byte leaves a residual argument
        push_text("a\\");
        line_q.push_back(CH_NUL);
        send_line();
        // one argument over the length limit, one exactly at it
        add_token(0, MAX_ARG_LEN_DEF + 1);
        line_q.push_back(CH_NUL);
        send_line();
        add_token(1, MAX_ARG_LEN_DEF);
        line_q.push_back(CH_NUL);
        send_line();
      end
      goal = sent_bytes + 75;
      while (sent_bytes < goal) begin
        make_line();
        send_line();
      end
    end
    wait_drained();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* quoted_argument_line_tokenizer.f */
hw/rtl/qaltok_pkg.sv
hw/rtl/quoted_argument_line_tokenizer.sv
tb/sv/tb_quoted_argument_line_tokenizer.sv
